### hw/rtl/rpa_pkg.sv
// shared codes for the region page allocator
`timescale 1ns / 1ps

package rpa_pkg;

	// operation codes on the mode input
	localparam logic [2:0] MODE_PUSH  = 3'd0;
	localparam logic [2:0] MODE_POP   = 3'd1;
	localparam logic [2:0] MODE_ALLOC = 3'd2;
	localparam logic [2:0] MODE_RESET = 3'd3;
	localparam logic [2:0] MODE_UNTIL = 3'd4;

	// result status codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_NOPAGE = 3'd1;
	localparam logic [2:0] ST_FULL   = 3'd2;
	localparam logic [2:0] ST_EMPTY  = 3'd3;
	localparam logic [2:0] ST_BAD    = 3'd4;

	// fixed field widths of the command and result ports
	localparam int MODE_W   = 3;
	localparam int REGION_W = 6;
	localparam int WORDS_W  = 9;
	localparam int STATUS_W = 3;
	localparam int PAGE_W   = 8;
	localparam int OFFSET_W = 9;

endpackage

### hw/rtl/rpa_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module rpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/region_page_allocator.sv
// region page allocator top level: free page list, region stack and command sequencer
`timescale 1ns / 1ps

// One command is taken when start is high and busy is low; its single result
// appears on status, region_id, page and offset for exactly one cycle with done
// high, and must be captured then. After reset the block initializes the page
// link memory with busy high. Push, pop, a bad request and an allocate that
// fits in the current page finish in the execute state; an allocate that chains
// a fresh page goes on to a link state; a region reset goes on to a read state,
// and then to the link state when it returns pages to the pool; pop-until stays
// in the execute state for each region popped. These steps are set by the single
// write port of the link memory and the registered reads of the link and
// descriptor memories. A new command may be started in the cycle done is high.
module region_page_allocator #(
	parameter int NUM_PAGES   = 256,
	parameter int PAGE_WORDS  = 256,
	parameter int MAX_REGIONS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [rpa_pkg::MODE_W-1:0]     mode,
	input  logic [rpa_pkg::REGION_W-1:0]   region,
	input  logic [rpa_pkg::WORDS_W-1:0]    words,
	output logic                           done,
	output logic [rpa_pkg::STATUS_W-1:0]   status,
	output logic [rpa_pkg::REGION_W-1:0]   region_id,
	output logic [rpa_pkg::PAGE_W-1:0]     page,
	output logic [rpa_pkg::OFFSET_W-1:0]   offset
);

	localparam int PW   = $clog2(NUM_PAGES);
	localparam int LW   = $clog2(NUM_PAGES + 1);
	localparam int OW   = $clog2(PAGE_WORDS + 1);
	localparam int CW   = $clog2(MAX_REGIONS + 1);
	localparam int RW   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int SW   = (OW > rpa_pkg::WORDS_W) ? OW + 1 : rpa_pkg::WORDS_W + 1;
	localparam int DW   = 2 * PW + OW;
	localparam logic [LW-1:0] LNULL = LW'(NUM_PAGES);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_RST_RD,
		S_LINK
	} state_t;

	typedef struct packed {
		logic [PW-1:0] first;
		logic [PW-1:0] last;
		logic [OW-1:0] fill;
	} desc_t;

	function automatic logic is_page(input logic [LW-1:0] p);
		is_page = 32'(p) < NUM_PAGES;
	endfunction

	function automatic logic [PW-1:0] pidx(input logic [LW-1:0] p);
		pidx = is_page(p) ? PW'(p) : '0;
	endfunction

	state_t                       state_q, nxt_state;
	logic [PW-1:0]                clr_q;
	logic [LW-1:0]                free_head_q, fh_nxt;
	logic [CW-1:0]                count_q, cnt_nxt;
	logic [rpa_pkg::MODE_W-1:0]   mode_q;
	logic [rpa_pkg::REGION_W-1:0] reg_q;
	logic [rpa_pkg::WORDS_W-1:0]  words_q;
	logic [PW-1:0]                fp_q, lp_q;
	logic [PW-1:0]                wr2_addr_q, wr2_addr;
	logic [LW-1:0]                wr2_data_q, wr2_data;
	logic                         wr2_en_q, wr2_en, wr2_ld;
	logic                         done_q, fin;
	logic [rpa_pkg::STATUS_W-1:0] status_q, res_status;
	logic [rpa_pkg::REGION_W-1:0] rid_q, res_rid;
	logic [rpa_pkg::PAGE_W-1:0]   page_q, res_page;
	logic [rpa_pkg::OFFSET_W-1:0] off_q, res_off;

	logic          lk_we;
	logic [PW-1:0] lk_waddr, lk_raddr;
	logic [LW-1:0] lk_wdata, lk_rdata;
	logic          ds_we;
	logic [RW-1:0] ds_waddr, ds_raddr;
	desc_t         ds_wdata, ds_rdata;

	logic          accept, full, reg_bad, do_pop, over;
	logic [SW-1:0] fill_sum;

	rpa_ram #(.WIDTH(LW), .DEPTH(NUM_PAGES)) u_link_ram (
		.clk   (clk),
		.we    (lk_we),
		.waddr (lk_waddr),
		.wdata (lk_wdata),
		.raddr (lk_raddr),
		.rdata (lk_rdata)
	);

	rpa_ram #(.WIDTH(DW), .DEPTH(MAX_REGIONS)) u_desc_ram (
		.clk   (clk),
		.we    (ds_we),
		.waddr (ds_waddr),
		.wdata (ds_wdata),
		.raddr (ds_raddr),
		.rdata (ds_rdata)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign full     = (count_q == CW'(MAX_REGIONS));
	assign reg_bad  = 16'(reg_q) >= 16'(count_q);
	assign fill_sum = SW'(ds_rdata.fill) + SW'(words_q);
	assign over     = fill_sum > SW'(PAGE_WORDS);
	assign do_pop   = (mode_q == rpa_pkg::MODE_UNTIL) ? 16'(count_q) > 16'(reg_q)
	                                                  : (count_q != '0);

	always_comb begin
		nxt_state  = state_q;
		fin        = 1'b0;
		fh_nxt     = free_head_q;
		cnt_nxt    = count_q;
		res_status = rpa_pkg::ST_OK;
		res_rid    = '0;
		res_page   = '0;
		res_off    = '0;
		lk_we      = 1'b0;
		lk_waddr   = clr_q;
		lk_wdata   = LW'(clr_q) + LW'(1);
		lk_raddr   = pidx(free_head_q);
		ds_we      = 1'b0;
		ds_waddr   = RW'(count_q);
		ds_wdata   = ds_rdata;
		ds_raddr   = RW'(count_q - CW'(2));
		wr2_ld     = 1'b0;
		wr2_addr   = ds_rdata.last;
		wr2_data   = free_head_q;
		wr2_en     = 1'b0;

		unique case (state_q)
			S_CLEAR: begin
				lk_we = 1'b1;
				if (clr_q == PW'(NUM_PAGES - 1)) begin
					nxt_state = S_IDLE;
				end
			end
			S_IDLE: begin
				if (mode == rpa_pkg::MODE_POP || mode == rpa_pkg::MODE_UNTIL) begin
					ds_raddr = RW'(count_q - CW'(1));
				end else begin
					ds_raddr = RW'(region);
				end
				if (accept) begin
					nxt_state = S_EXEC;
				end
			end
			S_EXEC: begin
				fin       = 1'b1;
				nxt_state = S_IDLE;
				unique case (mode_q)
					rpa_pkg::MODE_PUSH: begin
						if (full) begin
							res_status = rpa_pkg::ST_FULL;
						end else if (!is_page(free_head_q)) begin
							res_status = rpa_pkg::ST_NOPAGE;
						end else begin
							lk_we    = 1'b1;
							lk_waddr = PW'(free_head_q);
							lk_wdata = LNULL;
							fh_nxt   = is_page(lk_rdata) ? lk_rdata : LNULL;
							ds_we    = 1'b1;
							ds_wdata = '{first: PW'(free_head_q), last: PW'(free_head_q),
							             fill: '0};
							cnt_nxt  = count_q + CW'(1);
							res_rid  = rpa_pkg::REGION_W'(count_q);
							res_page = rpa_pkg::PAGE_W'(free_head_q);
						end
					end
					rpa_pkg::MODE_POP, rpa_pkg::MODE_UNTIL: begin
						if (do_pop) begin
							lk_we    = is_page(LW'(ds_rdata.last));
							lk_waddr = ds_rdata.last;
							lk_wdata = free_head_q;
							fh_nxt   = LW'(ds_rdata.first);
							cnt_nxt  = count_q - CW'(1);
							if (mode_q == rpa_pkg::MODE_UNTIL) begin
								fin       = 1'b0;
								nxt_state = S_EXEC;
							end
						end else if (mode_q == rpa_pkg::MODE_POP) begin
							res_status = rpa_pkg::ST_EMPTY;
						end
					end
					rpa_pkg::MODE_ALLOC: begin
						ds_waddr = RW'(reg_q);
						if (reg_bad || 16'(words_q) > 16'(PAGE_WORDS)) begin
							res_status = rpa_pkg::ST_BAD;
						end else if (over) begin
							if (!is_page(free_head_q)) begin
								res_status = rpa_pkg::ST_NOPAGE;
							end else begin
								lk_we     = 1'b1;
								lk_waddr  = PW'(free_head_q);
								lk_wdata  = LNULL;
								fh_nxt    = is_page(lk_rdata) ? lk_rdata : LNULL;
								ds_we     = 1'b1;
								ds_wdata  = '{first: ds_rdata.first, last: PW'(free_head_q),
								              fill: OW'(words_q)};
								res_page  = rpa_pkg::PAGE_W'(free_head_q);
								wr2_ld    = 1'b1;
								wr2_addr  = ds_rdata.last;
								wr2_data  = free_head_q;
								wr2_en    = is_page(LW'(ds_rdata.last));
								fin       = 1'b0;
								nxt_state = S_LINK;
							end
						end else begin
							ds_we    = 1'b1;
							ds_wdata = '{first: ds_rdata.first, last: ds_rdata.last,
							             fill: OW'(fill_sum)};
							res_page = rpa_pkg::PAGE_W'(ds_rdata.last);
							res_off  = rpa_pkg::OFFSET_W'(ds_rdata.fill);
						end
					end
					rpa_pkg::MODE_RESET: begin
						ds_waddr = RW'(reg_q);
						if (reg_bad) begin
							res_status = rpa_pkg::ST_BAD;
						end else begin
							ds_we     = 1'b1;
							ds_wdata  = '{first: ds_rdata.first, last: ds_rdata.first,
							              fill: '0};
							lk_raddr  = pidx(LW'(ds_rdata.first));
							fin       = 1'b0;
							nxt_state = S_RST_RD;
						end
					end
					default: begin
						res_status = rpa_pkg::ST_BAD;
					end
				endcase
			end
			S_RST_RD: begin
				if (is_page(LW'(fp_q)) && is_page(lk_rdata)) begin
					lk_we     = is_page(LW'(lp_q));
					lk_waddr  = lp_q;
					lk_wdata  = free_head_q;
					fh_nxt    = lk_rdata;
					wr2_ld    = 1'b1;
					wr2_addr  = fp_q;
					wr2_data  = LNULL;
					wr2_en    = 1'b1;
					nxt_state = S_LINK;
				end else begin
					fin       = 1'b1;
					nxt_state = S_IDLE;
				end
			end
			S_LINK: begin
				lk_we     = wr2_en_q;
				lk_waddr  = wr2_addr_q;
				lk_wdata  = wr2_data_q;
				fin       = 1'b1;
				nxt_state = S_IDLE;
			end
			default: begin
				nxt_state = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			free_head_q <= '0;
			count_q     <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= nxt_state;
			free_head_q <= fh_nxt;
			count_q     <= cnt_nxt;
			done_q      <= fin;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + PW'(1);
			end
			if (accept) begin
				mode_q  <= mode;
				reg_q   <= region;
				words_q <= words;
			end
			if (state_q == S_EXEC) begin
				status_q <= res_status;
				rid_q    <= res_rid;
				page_q   <= res_page;
				off_q    <= res_off;
				fp_q     <= ds_rdata.first;
				lp_q     <= ds_rdata.last;
			end
			if (wr2_ld) begin
				wr2_addr_q <= wr2_addr;
				wr2_data_q <= wr2_data;
				wr2_en_q   <= wr2_en;
			end
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign region_id = rid_q;
	assign page      = page_q;
	assign offset    = off_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= MAX_REGIONS)
		else $error("region count beyond stack depth");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		is_page(free_head_q) || free_head_q == LNULL)
		else $error("free list head is neither a page nor null");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(state_q) != S_IDLE && $past(state_q) != S_CLEAR)
		else $error("result strobe without a command in flight");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == rpa_pkg::ST_OK && $past(mode_q) == rpa_pkg::MODE_PUSH
		|-> 32'(count_q) == 32'(region_id) + 1)
		else $error("push result does not match stack count");
`endif

endmodule

### dv/testbench.sv
// self-checking testbench for the region page allocator: driver, monitor, scoreboard
`timescale 1ns / 1ps

module testbench;

	localparam int NUM_PAGES = 256;
	localparam int PAGE_WORDS = 256;
	localparam int MAX_REGIONS = 64;
	localparam logic [8:0] LINK_NULL = 9'(NUM_PAGES);
	localparam int PHASE_ITEMS = 625;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [rpa_pkg::STATUS_W-1:0] status;
		logic [rpa_pkg::REGION_W-1:0] region_id;
		logic [rpa_pkg::PAGE_W-1:0]   page;
		logic [rpa_pkg::OFFSET_W-1:0] offset;
	} alloc_result_t;

	typedef enum {TRAFFIC_GROW, TRAFFIC_STACK, TRAFFIC_SHRINK} traffic_t;

	class allocator_mirror;
		logic [8:0]                 link_tbl [NUM_PAGES];
		logic [8:0]                 free_head;
		int unsigned                depth;
		logic [rpa_pkg::PAGE_W-1:0] first_pg [MAX_REGIONS];
		logic [rpa_pkg::PAGE_W-1:0] last_pg [MAX_REGIONS];
		logic [8:0]                 fill [MAX_REGIONS];
		alloc_result_t              pending_responses [$];
		int unsigned                error_count;
		int unsigned                command_count;
		int unsigned                response_count;
		int unsigned                status_seen [5];

		function new();
			for (int i = 0; i < NUM_PAGES; i++) link_tbl[i] = 9'(i + 1);
			for (int i = 0; i < MAX_REGIONS; i++) begin
				first_pg[i] = '0;
				last_pg[i] = '0;
				fill[i] = '0;
			end
			for (int i = 0; i < 5; i++) status_seen[i] = 0;
			free_head = '0;
			depth = 0;
			error_count = 0;
			command_count = 0;
			response_count = 0;
		endfunction

		function void flag(string msg);
			error_count++;
			if (error_count <= MAX_REPORTS) $display("%s", msg);
		endfunction

		function bit grab_page(output logic [rpa_pkg::PAGE_W-1:0] pg);
			pg = '0;
			if (free_head[8]) return 0;
			pg = free_head[rpa_pkg::PAGE_W-1:0];
			free_head = link_tbl[pg][8] ? LINK_NULL : link_tbl[pg];
			link_tbl[pg] = LINK_NULL;
			return 1;
		endfunction

		function void drop_top();
			int unsigned t;
			t = depth - 1;
			link_tbl[last_pg[t]] = free_head;
			free_head = {1'b0, first_pg[t]};
			depth = t;
		endfunction

		// note an accepted command and queue the response it must produce
		function void apply_command(logic [2:0] m, logic [5:0] rg, logic [8:0] w);
			alloc_result_t r;
			logic [rpa_pkg::PAGE_W-1:0] pg;
			logic [rpa_pkg::PAGE_W-1:0] fp;
			r = '0;
			r.status = rpa_pkg::ST_OK;
			command_count++;
			case (m)
				rpa_pkg::MODE_PUSH: begin
					if (depth >= MAX_REGIONS) begin
						r.status = rpa_pkg::ST_FULL;
					end else if (!grab_page(pg)) begin
						r.status = rpa_pkg::ST_NOPAGE;
					end else begin
						first_pg[depth] = pg;
						last_pg[depth] = pg;
						fill[depth] = '0;
						r.region_id = 6'(depth);
						r.page = pg;
						depth++;
					end
				end
				rpa_pkg::MODE_POP: begin
					if (depth == 0) r.status = rpa_pkg::ST_EMPTY;
					else drop_top();
				end
				rpa_pkg::MODE_ALLOC: begin
					if (rg >= depth || w > PAGE_WORDS) begin
						r.status = rpa_pkg::ST_BAD;
					end else if (int'(fill[rg]) + int'(w) > PAGE_WORDS) begin
						if (!grab_page(pg)) begin
							r.status = rpa_pkg::ST_NOPAGE;
						end else begin
							link_tbl[last_pg[rg]] = {1'b0, pg};
							last_pg[rg] = pg;
							fill[rg] = w;
							r.page = pg;
						end
					end else begin
						r.page = last_pg[rg];
						r.offset = fill[rg];
						fill[rg] = fill[rg] + w;
					end
				end
				rpa_pkg::MODE_RESET: begin
					if (rg >= depth) begin
						r.status = rpa_pkg::ST_BAD;
					end else begin
						fp = first_pg[rg];
						if (!link_tbl[fp][8]) begin
							link_tbl[last_pg[rg]] = free_head;
							free_head = link_tbl[fp];
							link_tbl[fp] = LINK_NULL;
						end
						last_pg[rg] = fp;
						fill[rg] = '0;
					end
				end
				rpa_pkg::MODE_UNTIL: begin
					while (depth > rg) drop_top();
				end
				default: r.status = rpa_pkg::ST_BAD;
			endcase
			status_seen[r.status]++;
			pending_responses.push_back(r);
		endfunction

		function void check_response(alloc_result_t got);
			alloc_result_t want;
			response_count++;
			if (pending_responses.size() == 0) begin
				flag($sformatf("unexpected response: status %0d region_id %0d page %0d offset %0d",
					got.status, got.region_id, got.page, got.offset));
				return;
			end
			want = pending_responses.pop_front();
			if (got.status !== want.status || got.region_id !== want.region_id ||
				got.page !== want.page || got.offset !== want.offset)
				flag($sformatf({"mismatch on response %0d: expected status %0d region_id %0d ",
					"page %0d offset %0d, got status %0d region_id %0d page %0d offset %0d"},
					response_count, want.status, want.region_id, want.page, want.offset,
					got.status, got.region_id, got.page, got.offset));
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [rpa_pkg::MODE_W-1:0]   mode;
	logic [rpa_pkg::REGION_W-1:0] region;
	logic [rpa_pkg::WORDS_W-1:0]  words;
	logic                         done;
	logic [rpa_pkg::STATUS_W-1:0] status;
	logic [rpa_pkg::REGION_W-1:0] region_id;
	logic [rpa_pkg::PAGE_W-1:0]   page;
	logic [rpa_pkg::OFFSET_W-1:0] offset;
	int unsigned                  cycle_count;

	allocator_mirror mirror;

	region_page_allocator #(
		.NUM_PAGES  (NUM_PAGES),
		.PAGE_WORDS (PAGE_WORDS),
		.MAX_REGIONS(MAX_REGIONS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.mode     (mode),
		.region   (region),
		.words    (words),
		.done     (done),
		.status   (status),
		.region_id(region_id),
		.page     (page),
		.offset   (offset)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done !== 1'b0)
			mirror.check_response(alloc_result_t'{status, region_id, page, offset});
	end

	task automatic issue(input logic [2:0] m, input logic [5:0] rg, input logic [8:0] w);
		@(negedge clk);
		start <= 1'b1;
		mode <= m;
		region <= rg;
		words <= w;
		do @(posedge clk); while (busy !== 1'b0);
		mirror.apply_command(m, rg, w);
	endtask

	// idle cycles carry junk on the command fields
	task automatic hold_off(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
			mode <= rpa_pkg::MODE_W'($urandom);
			region <= rpa_pkg::REGION_W'($urandom);
			words <= rpa_pkg::WORDS_W'($urandom);
		end
	endtask

	task automatic sender_gap(input int pct);
		int n;
		n = 0;
		while (n < 20 && $urandom_range(99) < pct) n++;
		if (n > 0) hold_off(n);
	endtask

	function automatic logic [8:0] pick_words(input bit heavy);
		int r;
		r = $urandom_range(19);
		if (r == 0) return '0;
		if (r == 1) return 9'(PAGE_WORDS);
		if (r == 2) return 9'($urandom_range(511, PAGE_WORDS + 1));
		if (heavy) return 9'($urandom_range(PAGE_WORDS, 1));
		return 9'($urandom_range(32, 1));
	endfunction

	function automatic logic [5:0] pick_region();
		if (mirror.depth == 0 || $urandom_range(9) == 0) return 6'($urandom_range(63));
		return 6'($urandom_range(mirror.depth - 1));
	endfunction

	// pop-until floor, mostly at or just below the top of the stack
	function automatic logic [5:0] pick_floor();
		int d;
		d = (mirror.depth > 63) ? 63 : int'(mirror.depth);
		if ($urandom_range(3) == 0) return 6'($urandom_range(63));
		return 6'($urandom_range(d, (d > 4) ? d - 4 : 0));
	endfunction

	task automatic random_command(input traffic_t kind);
		int r;
		int c [5];
		logic [2:0] m;
		logic [5:0] rg;
		logic [8:0] w;
		case (kind)
			TRAFFIC_GROW: c = '{25, 75, 80, 86, 89};
			TRAFFIC_STACK: c = '{70, 90, 92, 96, 97};
			default: c = '{15, 35, 55, 80, 92};
		endcase
		r = $urandom_range(99);
		rg = pick_region();
		w = pick_words(kind == TRAFFIC_GROW);
		if (r < c[0]) begin
			m = rpa_pkg::MODE_PUSH;
		end else if (r < c[1]) begin
			m = rpa_pkg::MODE_ALLOC;
		end else if (r < c[2]) begin
			m = rpa_pkg::MODE_RESET;
		end else if (r < c[3]) begin
			m = rpa_pkg::MODE_POP;
		end else if (r < c[4]) begin
			m = rpa_pkg::MODE_UNTIL;
			rg = pick_floor();
		end else begin
			m = 3'($urandom_range(7));
			rg = 6'($urandom_range(63));
			w = 9'($urandom_range(511));
		end
		issue(m, rg, w);
	endtask

	initial begin
		int pct;
		int n;
		int block;
		traffic_t kind;
		mirror = new();
		arst_n = 1'b0;
		start = 1'b0;
		mode = '0;
		region = '0;
		words = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// error cases and a no-op pop-until on an empty allocator
		issue(rpa_pkg::MODE_POP, 6'd0, 9'd0);
		issue(rpa_pkg::MODE_ALLOC, 6'd0, 9'd1);
		issue(rpa_pkg::MODE_RESET, 6'd0, 9'd0);
		issue(rpa_pkg::MODE_UNTIL, 6'd0, 9'd0);
		for (int m = int'(rpa_pkg::MODE_UNTIL) + 1; m < (1 << rpa_pkg::MODE_W); m++)
			issue(3'(m), 6'($urandom_range(63)), 9'($urandom_range(511)));
		// fill a page exactly, then overflow into a chained page
		issue(rpa_pkg::MODE_PUSH, 6'd0, 9'd0);
		issue(rpa_pkg::MODE_ALLOC, 6'd0, 9'd0);
		issue(rpa_pkg::MODE_ALLOC, 6'd0, 9'(PAGE_WORDS));
		issue(rpa_pkg::MODE_ALLOC, 6'd0, 9'd0);
		issue(rpa_pkg::MODE_ALLOC, 6'd0, 9'd1);
		issue(rpa_pkg::MODE_ALLOC, 6'd0, 9'(PAGE_WORDS + 1));
		issue(rpa_pkg::MODE_ALLOC, 6'd0, 9'd511);
		issue(rpa_pkg::MODE_ALLOC, 6'd63, 9'd5);
		issue(rpa_pkg::MODE_PUSH, 6'd63, 9'd0);
		issue(rpa_pkg::MODE_ALLOC, 6'd1, 9'd200);
		issue(rpa_pkg::MODE_ALLOC, 6'd1, 9'd100);
		// resets that return pages and one that has none to return
		issue(rpa_pkg::MODE_RESET, 6'd0, 9'd0);
		issue(rpa_pkg::MODE_RESET, 6'd1, 9'd0);
		issue(rpa_pkg::MODE_RESET, 6'd1, 9'd0);
		issue(rpa_pkg::MODE_PUSH, 6'd0, 9'd0);
		issue(rpa_pkg::MODE_UNTIL, 6'd63, 9'd0);
		issue(rpa_pkg::MODE_POP, 6'd0, 9'd0);
		issue(rpa_pkg::MODE_UNTIL, 6'd0, 9'd0);

		for (int phase = 0; phase < 3; phase++) begin
			pct = (phase == 0) ? 7 : (phase == 1) ? 66 : 0;
			n = 0;
			while (n < PHASE_ITEMS) begin
				block = $urandom_range(160, 40);
				kind = traffic_t'($urandom_range(2));
				for (int k = 0; k < block && n < PHASE_ITEMS; k++) begin
					sender_gap(pct);
					random_command(kind);
					n++;
				end
			end
		end
		hold_off(1);

		while (mirror.pending_responses.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d commands and checked %0d responses",
			mirror.command_count, mirror.response_count);
		$display("outcomes: ok %0d, no free page %0d, stack full %0d, stack empty %0d, bad %0d",
			mirror.status_seen[rpa_pkg::ST_OK], mirror.status_seen[rpa_pkg::ST_NOPAGE],
			mirror.status_seen[rpa_pkg::ST_FULL], mirror.status_seen[rpa_pkg::ST_EMPTY],
			mirror.status_seen[rpa_pkg::ST_BAD]);
		if (mirror.pending_responses.size() != 0)
			mirror.flag($sformatf("%0d responses never arrived", mirror.pending_responses.size()));
		if (mirror.error_count == 0) begin
			$display("testbench passed");
		end else begin
			$display("%0d errors", mirror.error_count);
			$display("testbench failed");
		end
		$finish;
	end

endmodule
